// ----- rtl/mlfq_pkg.sv -----
// mlfq_pkg: shared constants, codes and item types of the feedback queue scheduler
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int MAX_PROCS  = 8;
  localparam int NUM_LEVELS = 3;
  localparam int ID_W       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W      = $clog2(MAX_PROCS + 1);
  localparam int BURST_W    = 16;
  localparam int QNT_W      = 16;
  localparam int TIME_W     = 20;
  localparam int PID_W      = 4;
  localparam int LVL_W      = 2;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_QUANTUM1 = 2'd0,
    REG_QUANTUM2 = 2'd1,
    REG_QUANTUM3 = 2'd2
  } reg_idx_t;

  typedef enum logic [LVL_W-1:0] {
    LEVEL1 = 2'd0,
    LEVEL2 = 2'd1,
    LEVEL3 = 2'd2
  } level_t;

  typedef struct packed {
    op_t                op;
    logic [BURST_W-1:0] burst;
  } in_item_t;

  typedef struct packed {
    logic [PID_W-1:0]  proc_num;
    logic [LVL_W-1:0]  level;
    logic [TIME_W-1:0] slice_start;
    logic [TIME_W-1:0] slice_end;
    logic              finished;
    logic [TIME_W-1:0] wait_len;
    logic              idle;
  } out_item_t;

endpackage

// ----- rtl/multilevel_feedback_queue_scheduler.sv -----
// multilevel_feedback_queue_scheduler: three-level feedback queue scheduler, one item per cycle
//
// Input items (in_valid / in_stall / in_data) either load a process with a burst time
// into level 1 (op load) or run one time slice (op step). Each step item gives exactly
// one result item on out_valid / out_stall / out_data; a load item gives none.
// The three quanta are written over the APB-style port at byte addresses 0, 4 and 8
// and read back there; pready is always high.
// An accepted item sits in the input register while its slice is worked out in that
// cycle; the state and the result register are written when it executes. One item is
// taken every cycle unless a step stalls; the single read-modify-write of queue,
// remaining time and clock per cycle sets this.
// When the receiver stalls, the result register holds its item; a load still goes
// through, while a step waits in the input register and in_stall rises once it is full.
// Synchronous active-low reset empties all queues, clears the process count, the
// current level and the simulated time, and restores quanta 1, 2 and 4. Process
// storage is not cleared: nothing is read from it before it is loaded.
`timescale 1ns / 1ps
module multilevel_feedback_queue_scheduler (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  mlfq_pkg::in_item_t       in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output mlfq_pkg::out_item_t      out_data,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [mlfq_pkg::ADDR_W-1:0] paddr,
  input  logic [mlfq_pkg::DATA_W-1:0] pwdata,
  output logic [mlfq_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import mlfq_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  // configuration
  logic [QNT_W-1:0] qnt1_r, qnt2_r, qnt3_r;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  // item handshake
  logic      item_v_r;
  in_item_t  item_r;
  logic      out_valid_r;
  out_item_t out_r;
  logic      out_free;
  logic      exec;

  // scheduler state
  logic [ID_W-1:0]    ids_r   [NUM_LEVELS][MAX_PROCS];
  logic [BURST_W-1:0] rem_r   [MAX_PROCS];
  logic [BURST_W-1:0] burst_r [MAX_PROCS];
  logic [ID_W-1:0]    heads_r [NUM_LEVELS];
  logic [ID_W-1:0]    heads_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]   counts_r  [NUM_LEVELS];
  logic [CNT_W-1:0]   counts_nxt [NUM_LEVELS];
  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic [LVL_W-1:0]   cur_r, cur_nxt;
  logic [TIME_W-1:0]  sim_r, sim_nxt;

  // write strobes for the process stores
  logic               ids_we;
  logic [LVL_W-1:0]   ids_lv;
  logic [ID_W-1:0]    ids_pos;
  logic [ID_W-1:0]    ids_val;
  logic               rem_we;
  logic [ID_W-1:0]    rem_idx;
  logic [BURST_W-1:0] rem_val;
  logic               burst_we;

  out_item_t res;

  // slice datapath
  logic               found;
  logic [LVL_W-1:0]   sel_lv;
  logic [LVL_W-1:0]   cand;
  logic [ID_W-1:0]    head_idx;
  logic [BURST_W-1:0] rem;
  logic [QNT_W-1:0]   qnt;
  logic [BURST_W-1:0] run;
  logic [BURST_W-1:0] rem_left;
  logic [TIME_W-1:0]  end_t;
  logic [LVL_W-1:0]   tgt;
  logic               q3_small;

  function automatic logic [LVL_W-1:0] lvl_add(input logic [LVL_W-1:0] lv,
                                               input logic [LVL_W-1:0] k);
    logic [LVL_W:0] s;
    s = {1'b0, lv} + {1'b0, k};
    if (s >= (LVL_W+1)'(NUM_LEVELS)) begin
      s = s - (LVL_W+1)'(NUM_LEVELS);
    end
    return s[LVL_W-1:0];
  endfunction

  function automatic logic [ID_W-1:0] slot_add(input logic [ID_W-1:0] h,
                                               input logic [CNT_W-1:0] n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(n);
    if (s >= SUM_W'(MAX_PROCS)) begin
      s = s - SUM_W'(MAX_PROCS);
    end
    return s[ID_W-1:0];
  endfunction

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      REG_QUANTUM1: prdata = DATA_W'(qnt1_r);
      REG_QUANTUM2: prdata = DATA_W'(qnt2_r);
      REG_QUANTUM3: prdata = DATA_W'(qnt3_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qnt1_r <= QNT_W'(1);
      qnt2_r <= QNT_W'(2);
      qnt3_r <= QNT_W'(4);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_QUANTUM1: qnt1_r <= pwdata[QNT_W-1:0];
        REG_QUANTUM2: qnt2_r <= pwdata[QNT_W-1:0];
        REG_QUANTUM3: qnt3_r <= pwdata[QNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // handshake: a load needs no result slot, a step needs a free or draining one
  assign out_free  = !out_valid_r || !out_stall;
  assign exec      = item_v_r && ((item_r.op == OP_LOAD) || out_free);
  assign in_stall  = item_v_r && !exec;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // level search and slice arithmetic
  always_comb begin
    found  = 1'b0;
    sel_lv = cur_r;
    cand   = cur_r;
    // walk backwards so the nearest non-empty level wins
    for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
      cand = lvl_add(cur_r, LVL_W'(k));
      if (counts_r[cand] != '0) begin
        found  = 1'b1;
        sel_lv = cand;
      end
    end

    head_idx = ids_r[sel_lv][heads_r[sel_lv]];
    rem      = rem_r[head_idx];
    case (level_t'(sel_lv))
      LEVEL1:  qnt = qnt1_r;
      LEVEL2:  qnt = qnt2_r;
      LEVEL3:  qnt = qnt3_r;
      default: qnt = qnt1_r;
    endcase
    run      = (rem < qnt) ? rem : qnt;
    rem_left = rem - run;
    end_t    = sim_r + TIME_W'(run);
  end

  // state update
  always_comb begin
    heads_nxt  = heads_r;
    counts_nxt = counts_r;
    loaded_nxt = loaded_r;
    cur_nxt    = cur_r;
    sim_nxt    = sim_r;
    ids_we     = 1'b0;
    ids_lv     = LEVEL1;
    ids_pos    = '0;
    ids_val    = head_idx;
    rem_we     = 1'b0;
    rem_idx    = head_idx;
    rem_val    = rem_left;
    burst_we   = 1'b0;
    tgt        = LEVEL1;
    q3_small   = 1'b0;

    res              = '0;
    res.slice_start  = sim_r;
    res.slice_end    = sim_r;
    res.idle         = 1'b1;

    if (item_r.op == OP_LOAD) begin
      if (loaded_r < CNT_W'(MAX_PROCS)) begin
        rem_we     = 1'b1;
        burst_we   = 1'b1;
        rem_idx    = loaded_r[ID_W-1:0];
        rem_val    = item_r.burst;
        if (counts_r[LEVEL1] < CNT_W'(MAX_PROCS)) begin
          ids_we   = 1'b1;
          ids_lv   = LEVEL1;
          ids_pos  = slot_add(heads_r[LEVEL1], counts_r[LEVEL1]);
          ids_val  = loaded_r[ID_W-1:0];
          counts_nxt[LEVEL1] = counts_r[LEVEL1] + CNT_W'(1);
        end
        loaded_nxt = loaded_r + CNT_W'(1);
      end
    end else if (found) begin
      cur_nxt = sel_lv;
      sim_nxt = end_t;
      rem_we  = 1'b1;
      // pop the head of the chosen level
      heads_nxt[sel_lv]  = slot_add(heads_r[sel_lv], CNT_W'(1));
      counts_nxt[sel_lv] = counts_r[sel_lv] - CNT_W'(1);

      res.proc_num   = PID_W'(SUM_W'(head_idx) + SUM_W'(1));
      res.level      = sel_lv + LVL_W'(1);
      res.slice_end  = end_t;
      res.idle       = 1'b0;

      if (rem_left == '0) begin
        res.finished = 1'b1;
        res.wait_len = end_t - TIME_W'(burst_r[head_idx]);
      end else begin
        // move rules, on counts after the pop
        q3_small = counts_nxt[LEVEL3] <= CNT_W'(1);
        if (sel_lv == LEVEL3 && q3_small && counts_nxt[LEVEL1] != '0) begin
          tgt = LEVEL1;
        end else if (sel_lv == LEVEL1 && q3_small && counts_nxt[LEVEL1] == '0 &&
                     counts_nxt[LEVEL2] == '0) begin
          tgt = LEVEL1;
        end else if (sel_lv == LEVEL1) begin
          tgt = (rem_left > BURST_W'(1)) ? LEVEL2 : LEVEL1;
        end else if (sel_lv == LEVEL2) begin
          tgt = (rem_left > BURST_W'(2)) ? LEVEL3 : LEVEL2;
        end else if (rem_left == BURST_W'(1)) begin
          tgt = LEVEL1;
        end else if (rem_left == BURST_W'(2)) begin
          tgt = LEVEL2;
        end else begin
          tgt = LEVEL3;
        end
        if (counts_nxt[tgt] < CNT_W'(MAX_PROCS)) begin
          ids_we  = 1'b1;
          ids_lv  = tgt;
          ids_pos = slot_add(heads_nxt[tgt], counts_nxt[tgt]);
          counts_nxt[tgt] = counts_nxt[tgt] + CNT_W'(1);
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      loaded_r    <= '0;
      cur_r       <= LEVEL1;
      sim_r       <= '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        heads_r[l]  <= '0;
        counts_r[l] <= '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        item_v_r <= 1'b1;
      end else if (exec) begin
        item_v_r <= 1'b0;
      end
      if (exec && item_r.op == OP_STEP) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (exec) begin
        loaded_r <= loaded_nxt;
        cur_r    <= cur_nxt;
        sim_r    <= sim_nxt;
        heads_r  <= heads_nxt;
        counts_r <= counts_nxt;
      end
    end
  end

  // payload registers and process stores
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_data;
    end
    if (exec && item_r.op == OP_STEP) begin
      out_r <= res;
    end
    if (exec && ids_we) begin
      ids_r[ids_lv][ids_pos] <= ids_val;
    end
    if (exec && rem_we) begin
      rem_r[rem_idx] <= rem_val;
    end
    if (exec && burst_we) begin
      burst_r[rem_idx] <= item_r.burst;
    end
  end

endmodule
